// ----- design/fft_pkg.sv -----
// ----------------------------------------------------------------------------
// fft_pkg: shared types and constants
// Widths, twiddle table and state encoding for the 64-point radix-2 FFT.
// ----------------------------------------------------------------------------
package fft_pkg;

  localparam int LogPoints = 6;
  localparam int FracBits = 7;
  localparam int Points = 1 << LogPoints;
  localparam int DataW = 16;
  localparam int AddrW = LogPoints;
  localparam int StageW = 3;
  localparam int QueueDepth = 2;

  typedef logic signed [DataW-1:0] sample_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
  } cplx_t;

  typedef struct packed {
    cplx_t             data;
    logic [AddrW-1:0]  addr;
    logic              last;
  } load_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // cos and -sin in Q7, truncated toward zero
  function automatic logic [2*DataW-1:0] twiddle(input logic [AddrW-2:0] t);
    logic signed [DataW-1:0] c;
    logic signed [DataW-1:0] s;
    begin
      case (t)
        5'd0:  begin c = 16'sd128;  s = 16'sd0;    end
        5'd1:  begin c = 16'sd127;  s = -16'sd12;  end
        5'd2:  begin c = 16'sd125;  s = -16'sd24;  end
        5'd3:  begin c = 16'sd122;  s = -16'sd37;  end
        5'd4:  begin c = 16'sd118;  s = -16'sd48;  end
        5'd5:  begin c = 16'sd112;  s = -16'sd60;  end
        5'd6:  begin c = 16'sd106;  s = -16'sd71;  end
        5'd7:  begin c = 16'sd98;   s = -16'sd81;  end
        5'd8:  begin c = 16'sd90;   s = -16'sd90;  end
        5'd9:  begin c = 16'sd81;   s = -16'sd98;  end
        5'd10: begin c = 16'sd71;   s = -16'sd106; end
        5'd11: begin c = 16'sd60;   s = -16'sd112; end
        5'd12: begin c = 16'sd48;   s = -16'sd118; end
        5'd13: begin c = 16'sd37;   s = -16'sd122; end
        5'd14: begin c = 16'sd24;   s = -16'sd125; end
        5'd15: begin c = 16'sd12;   s = -16'sd127; end
        5'd16: begin c = 16'sd0;    s = -16'sd128; end
        5'd17: begin c = -16'sd12;  s = -16'sd127; end
        5'd18: begin c = -16'sd24;  s = -16'sd125; end
        5'd19: begin c = -16'sd37;  s = -16'sd122; end
        5'd20: begin c = -16'sd48;  s = -16'sd118; end
        5'd21: begin c = -16'sd60;  s = -16'sd112; end
        5'd22: begin c = -16'sd71;  s = -16'sd106; end
        5'd23: begin c = -16'sd81;  s = -16'sd98;  end
        5'd24: begin c = -16'sd90;  s = -16'sd90;  end
        5'd25: begin c = -16'sd98;  s = -16'sd81;  end
        5'd26: begin c = -16'sd106; s = -16'sd71;  end
        5'd27: begin c = -16'sd112; s = -16'sd60;  end
        5'd28: begin c = -16'sd118; s = -16'sd48;  end
        5'd29: begin c = -16'sd122; s = -16'sd37;  end
        5'd30: begin c = -16'sd125; s = -16'sd24;  end
        default: begin c = -16'sd127; s = -16'sd12; end
      endcase
      twiddle = {c, s};
    end
  endfunction

  function automatic logic [AddrW-1:0] bit_rev(input logic [AddrW-1:0] v);
    logic [AddrW-1:0] r;
    begin
      for (int b = 0; b < AddrW; b++) begin
        r[b] = v[AddrW-1-b];
      end
      bit_rev = r;
    end
  endfunction

endpackage

// ----- design/fft_front.sv -----
// ----------------------------------------------------------------------------
// fft_front: sample intake
// Counts samples, tags each with its bit-reversed address and the frame end,
// and pushes it into a short queue toward the core.
// ----------------------------------------------------------------------------
module fft_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [31:0]     in_tdata,
  output logic            q_valid,
  input  logic            q_ready,
  output fft_pkg::load_t  q_item
);

  fft_pkg::load_t                  mem_r [fft_pkg::QueueDepth];
  logic                            wr_ptr_r, wr_ptr_nxt;
  logic                            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                      count_r, count_nxt;
  logic [fft_pkg::AddrW-1:0]       load_cnt_r, load_cnt_nxt;
  logic                            push;
  logic                            pop;
  fft_pkg::load_t                  new_item;

  assign in_tready = (count_r != 2'(fft_pkg::QueueDepth));
  assign push = in_tvalid && in_tready;
  assign q_valid = (count_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rd_ptr_r];

  always_comb begin
    new_item.data.re = in_tdata[15:0];
    new_item.data.im = in_tdata[31:16];
    new_item.addr = fft_pkg::bit_rev(load_cnt_r);
    new_item.last = &load_cnt_r;
    load_cnt_nxt = push ? load_cnt_r + 1'b1 : load_cnt_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
      load_cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
      load_cnt_r <= load_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(fft_pkg::QueueDepth)) else $error("queue overfilled");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count wrong");
  a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
    push && new_item.last |=> load_cnt_r == '0) else $error("frame count wrong");
`endif

endmodule

// ----- design/fft_core.sv -----
// ----------------------------------------------------------------------------
// fft_core: in-place butterfly engine
// Stores a frame, runs six stages of butterflies, one at a time, using
// a single-port working memory, then emits bins in natural order.
// ----------------------------------------------------------------------------
module fft_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  fft_pkg::load_t  q_item,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [39:0]     out_tdata,
  output logic            out_tlast
);

  localparam int AW = fft_pkg::AddrW;

  fft_pkg::cplx_t               ram_r [fft_pkg::Points];
  fft_pkg::cplx_t               rd_r;
  fft_pkg::state_t              state_r, state_nxt;
  logic [fft_pkg::StageW-1:0]   stage_r, stage_nxt;
  logic [AW-2:0]                bfly_r, bfly_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [AW:0]                  emit_cnt_r, emit_cnt_nxt;
  logic                         rd_vld_r;
  logic                         ovalid_r;
  logic [AW-1:0]                oidx_r;
  logic                         olast_r;
  fft_pkg::cplx_t               odata_r;
  fft_pkg::cplx_t               a_r;
  logic signed [31:0]           rc_r, rs_r, ic_r, is_r;
  fft_pkg::cplx_t               top, bot;
  fft_pkg::cplx_t               pa;
  logic [AW-1:0]                i1, i2;
  logic [AW-2:0]                tf;
  logic [AW-2:0]                span_mask;
  logic signed [15:0]           tw_c, tw_s;
  logic                         mem_we;
  logic                         mem_re;
  logic [AW-1:0]                mem_addr;
  fft_pkg::cplx_t               mem_wd;
  logic                         emit_rd;
  logic                         out_free;
  logic signed [15:0]           rc, rs, ic, is;

  always_comb begin
    span_mask = (AW-1)'((1 << stage_r) - 1);
    i1 = ({1'b0, bfly_r & ~span_mask} << 1) | {1'b0, bfly_r & span_mask};
    i2 = i1 | AW'(1 << stage_r);
    tf = (AW-1)'((bfly_r & span_mask) << (AW - 1 - int'(stage_r)));
    {tw_c, tw_s} = fft_pkg::twiddle(tf);
    rc = 16'(rc_r >>> fft_pkg::FracBits);
    rs = 16'(rs_r >>> fft_pkg::FracBits);
    ic = 16'(ic_r >>> fft_pkg::FracBits);
    is = 16'(is_r >>> fft_pkg::FracBits);
  end

  assign out_free = !ovalid_r || out_tready;
  assign q_ready = (state_r == fft_pkg::ST_LOAD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fft_pkg::ST_LOAD: begin
        if (q_valid && q_item.last) begin
          state_nxt = fft_pkg::ST_CALC;
        end
      end
      fft_pkg::ST_CALC: begin
        if (phase_r == 2'd3 && &bfly_r && stage_r == 3'(AW - 1)) begin
          state_nxt = fft_pkg::ST_DRAIN;
        end
      end
      fft_pkg::ST_DRAIN: begin
        state_nxt = fft_pkg::ST_EMIT;
      end
      fft_pkg::ST_EMIT: begin
        if (emit_cnt_r == (AW+1)'(fft_pkg::Points) && !rd_vld_r) begin
          state_nxt = fft_pkg::ST_LOAD;
        end
      end
      default: state_nxt = fft_pkg::ST_LOAD;
    endcase
  end

  // phases: 0 read b, 1 read a, 2 write bottom, 3 write top
  always_comb begin
    stage_nxt = stage_r;
    bfly_nxt = bfly_r;
    phase_nxt = phase_r;
    emit_cnt_nxt = emit_cnt_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_addr = q_item.addr;
    mem_wd = q_item.data;
    emit_rd = 1'b0;
    case (state_r)
      fft_pkg::ST_LOAD: begin
        mem_we = q_valid;
        stage_nxt = '0;
        bfly_nxt = '0;
        phase_nxt = 2'd0;
        emit_cnt_nxt = '0;
      end
      fft_pkg::ST_CALC: begin
        phase_nxt = phase_r + 2'd1;
        case (phase_r)
          2'd0: begin
            mem_re = 1'b1;
            mem_addr = i2;
          end
          2'd1: begin
            mem_re = 1'b1;
            mem_addr = i1;
          end
          2'd2: begin
            mem_we = 1'b1;
            mem_addr = i2;
            mem_wd = bot;
          end
          default: begin
            mem_we = 1'b1;
            mem_addr = i1;
            mem_wd = top;
            bfly_nxt = bfly_r + 1'b1;
            if (&bfly_r) begin
              stage_nxt = stage_r + 3'd1;
            end
          end
        endcase
      end
      fft_pkg::ST_EMIT: begin
        mem_addr = emit_cnt_r[AW-1:0];
        if (emit_cnt_r != (AW+1)'(fft_pkg::Points) && out_free && !rd_vld_r) begin
          emit_rd = 1'b1;
          mem_re = 1'b1;
          emit_cnt_nxt = emit_cnt_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ram_r[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= ram_r[mem_addr];
    end
  end

  // b is on rd_r in phase 1 and feeds the products, a is on rd_r in phase 2
  always_ff @(posedge clk) begin
    if (state_r == fft_pkg::ST_CALC && phase_r == 2'd1) begin
      rc_r <= tw_c * rd_r.re;
      rs_r <= tw_s * rd_r.re;
      ic_r <= tw_c * rd_r.im;
      is_r <= tw_s * rd_r.im;
    end
    if (state_r == fft_pkg::ST_CALC && phase_r == 2'd2) begin
      a_r <= rd_r;
    end
  end

  always_comb begin
    pa = (phase_r == 2'd2) ? rd_r : a_r;
    bot.re = 16'(pa.re - rc + is);
    bot.im = 16'(pa.im - rs - ic);
    top.re = 16'(pa.re + rc - is);
    top.im = 16'(pa.im + rs + ic);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fft_pkg::ST_LOAD;
      stage_r <= '0;
      bfly_r <= '0;
      phase_r <= 2'd0;
      emit_cnt_r <= '0;
      rd_vld_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      bfly_r <= bfly_nxt;
      phase_r <= phase_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      rd_vld_r <= emit_rd;
      if (rd_vld_r) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_rd) begin
      oidx_r <= emit_cnt_r[AW-1:0];
      olast_r <= &emit_cnt_r[AW-1:0];
    end
    if (rd_vld_r) begin
      odata_r <= rd_r;
    end
  end

  logic [AW-1:0] oidx_q;
  logic          olast_q;
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      oidx_q <= oidx_r;
      olast_q <= olast_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {2'b00, oidx_q, odata_r.im, odata_r.re};
  assign out_tlast = olast_q;

`ifndef SYNTHESIS
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != fft_pkg::ST_LOAD |-> !q_ready) else $error("intake while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
  a_single_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> out_free) else $error("fetch without room");
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    emit_rd |-> state_r == fft_pkg::ST_EMIT) else $error("stray fetch");
`endif

endmodule

// ----- design/fixed_point_fft_radix2_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_point_fft_radix2_unit: 64-point radix-2 DIT FFT, Q7 complex
// Front intake queue feeding an in-place butterfly engine.
// ----------------------------------------------------------------------------
// usage:
//   in_* takes one complex sample per item, re in bits 15:0, im in 31:16
//   out_* gives 64 bins per frame in natural order, tlast on bin 63
//   a frame: 64 load items, one per cycle while in_tvalid is high, then
//   six stages of 32 butterflies, each reading b and a, then writing bottom
//   and top (one single-port memory access per cycle), then 64 bins, each
//   read waiting for the previous bin to be registered and for output room
//   the two-item front queue takes up to two samples while the core is busy
//   first bin: last butterfly, drain state, first emit read, output register
//   reset clears counters and queue; the working memory needs no clearing
//   out_tready low holds the current bin and pauses the memory reads
// ----------------------------------------------------------------------------
module fixed_point_fft_radix2_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_real, sample_imag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // bin_real, bin_imag, bin_index, zero pad
  output logic        out_tlast   // frame_end
);

  logic           q_valid;
  logic           q_ready;
  fft_pkg::load_t q_item;

  fft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  fft_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
